// ===== hw/rtl/gmbd_pkg.sv =====
package gmbd_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = VW + 1;
	localparam int EW = 12;
	localparam logic [CW-1:0] VCOUNT_RESET = CW'(MAX_VERTICES);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_BFS    = 2'd2,
		ACT_DFS    = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		OP_IDLE   = 4'd0,
		OP_LOAD   = 4'd1,
		OP_EDGE_A = 4'd2,
		OP_EDGE_B = 4'd3,
		OP_FLUSH  = 4'd4,
		OP_BPOP   = 4'd5,
		OP_BVISIT = 4'd6,
		OP_BSCAN  = 4'd7,
		OP_DSCAN  = 4'd8,
		OP_DPOP   = 4'd9
	} dp_op_t;

	typedef struct packed {
		logic       in_oor;
		logic [1:0] in_action;
		logic       need;
		logic       out_free;
		logic       q_empty;
		logic       emit_ok;
		logic       found;
		logic       stack_empty;
	} dp_status_t;

	typedef struct packed {
		logic          found;
		logic [VW-1:0] idx;
	} first_t;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [CW-1:0] nxt;
	} stack_entry_t;

	function automatic first_t first_one(input logic [MAX_VERTICES-1:0] vec);
		first_t r;
		r.found = 1'b0;
		r.idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				r.found = 1'b1;
				r.idx = VW'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/gmbd_if.sv =====
interface gmbd_in_if import gmbd_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    action;
	logic [VW-1:0] vertex_a;
	logic [VW-1:0] vertex_b;

	modport source (output valid, action, vertex_a, vertex_b, input ready);
	modport sink (input valid, action, vertex_a, vertex_b, output ready);
endinterface

interface gmbd_out_if import gmbd_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [VW-1:0] visited_vertex;
	logic          last;
	logic          status;
	logic [EW-1:0] edge_count;

	modport source (output valid, visited_vertex, last, status, edge_count, input ready);
	modport sink (input valid, visited_vertex, last, status, edge_count, output ready);
endinterface

// ===== hw/rtl/gmbd_ctrl.sv =====
module gmbd_ctrl import gmbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_op_t     op
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_EDGE_A = 9'b000000010,
		S_EDGE_B = 9'b000000100,
		S_FLUSH  = 9'b000001000,
		S_BPOP   = 9'b000010000,
		S_BVISIT = 9'b000100000,
		S_BSCAN  = 9'b001000000,
		S_DSCAN  = 9'b010000000,
		S_DPOP   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		op = OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					if (st.in_oor)
						state_d = S_FLUSH;
					else begin
						case (st.in_action)
							ACT_INSERT, ACT_REMOVE: state_d = S_EDGE_A;
							ACT_BFS: state_d = S_BPOP;
							default: state_d = S_DSCAN;
						endcase
					end
				end
			end
			S_EDGE_A: begin
				op = OP_EDGE_A;
				state_d = st.need ? S_EDGE_B : S_FLUSH;
			end
			S_EDGE_B: begin
				op = OP_EDGE_B;
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				op = OP_FLUSH;
				if (st.out_free)
					state_d = S_IDLE;
			end
			S_BPOP: begin
				op = OP_BPOP;
				state_d = st.q_empty ? S_FLUSH : S_BVISIT;
			end
			S_BVISIT: begin
				op = OP_BVISIT;
				if (st.emit_ok)
					state_d = S_BSCAN;
			end
			S_BSCAN: begin
				op = OP_BSCAN;
				if (!st.found)
					state_d = S_BPOP;
			end
			S_DSCAN: begin
				op = OP_DSCAN;
				if (!st.found)
					state_d = st.stack_empty ? S_FLUSH : S_DPOP;
			end
			S_DPOP: begin
				op = OP_DPOP;
				state_d = S_DSCAN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== hw/rtl/gmbd_dp.sv =====
module gmbd_dp import gmbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_wdata,
	input  dp_op_t        op,
	output dp_status_t    st,
	input  logic [1:0]    in_action,
	input  logic [VW-1:0] in_a,
	input  logic [VW-1:0] in_b,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [VW-1:0] out_vertex,
	output logic          out_last,
	output logic          out_status,
	output logic [EW-1:0] out_edges
);

	localparam int N = MAX_VERTICES;

	logic [N-1:0]  adj_mem [N];
	logic [N-1:0]  row_valid_q;
	logic [N-1:0]  row_rd_q;
	logic          row_rd_vld_q;
	logic [VW-1:0] q_mem [N];
	logic [VW-1:0] q_rd_q;
	stack_entry_t  s_mem [N];
	stack_entry_t  s_rd_q;

	logic [CW-1:0] vcount_q;
	logic [EW-1:0] edges_q;
	logic [1:0]    act_q;
	logic [VW-1:0] a_q, b_q;
	logic [N-1:0]  visited_q;
	logic [CW-1:0] head_q, tail_q, sp_q;
	logic [VW-1:0] cur_v_q;
	logic [CW-1:0] cur_next_q;
	logic          pend_vld_q;
	logic [VW-1:0] pend_v_q;
	logic          pend_st_q;
	logic          out_valid_q;

	logic [CW-1:0] n_used;
	logic [N-1:0]  nmask, row, cand_b, cand_d;
	first_t        fb, fd;
	logic          oor, need, out_free, emit_ok, emit_now, push;
	logic          row_we, row_re;
	logic [VW-1:0] row_waddr, row_raddr, emit_v;
	logic [N-1:0]  row_wdata;
	logic          ins;

	assign n_used = (vcount_q > CW'(N)) ? CW'(N) : vcount_q;
	assign nmask = ~({N{1'b1}} << n_used);
	assign row = row_rd_vld_q ? row_rd_q : '0;
	assign cand_b = row & ~visited_q & nmask;
	assign cand_d = cand_b & ({N{1'b1}} << cur_next_q);
	assign fb = first_one(cand_b);
	assign fd = first_one(cand_d);
	assign oor = ({1'b0, in_a} >= n_used) || (!in_action[1] && ({1'b0, in_b} >= n_used));
	assign ins = (act_q == ACT_INSERT);
	assign need = ins ? !row[b_q] : row[b_q];
	assign out_free = !out_valid_q || out_ready;
	assign emit_ok = !pend_vld_q || out_free;
	assign emit_now = ((op == OP_BVISIT) && emit_ok) || ((op == OP_DSCAN) && fd.found && emit_ok);
	assign push = ((op == OP_FLUSH) && out_free) || (emit_now && pend_vld_q);
	assign emit_v = (op == OP_BVISIT) ? q_rd_q : fd.idx;

	assign st.in_oor = oor;
	assign st.in_action = in_action;
	assign st.need = need;
	assign st.out_free = out_free;
	assign st.q_empty = (head_q == tail_q);
	assign st.emit_ok = emit_ok;
	assign st.found = (op == OP_BSCAN) ? fb.found : fd.found;
	assign st.stack_empty = (sp_q == '0);

	always_comb begin
		row_we = 1'b0;
		row_waddr = a_q;
		row_wdata = ins ? (row | (N'(1) << b_q)) : (row & ~(N'(1) << b_q));
		row_re = 1'b0;
		row_raddr = in_a;
		case (op)
			OP_LOAD: row_re = 1'b1;
			OP_EDGE_A: begin
				row_we = need;
				row_re = need;
				row_raddr = b_q;
			end
			OP_EDGE_B: begin
				row_we = 1'b1;
				row_waddr = b_q;
				row_wdata = ins ? (row | (N'(1) << a_q)) : (row & ~(N'(1) << a_q));
			end
			OP_BVISIT: begin
				row_re = emit_ok;
				row_raddr = q_rd_q;
			end
			OP_DSCAN: begin
				row_re = fd.found && emit_ok;
				row_raddr = fd.idx;
			end
			OP_DPOP: begin
				row_re = 1'b1;
				row_raddr = s_rd_q.v;
			end
			default: row_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we)
			adj_mem[row_waddr] <= row_wdata;
		if (row_re) begin
			row_rd_q <= adj_mem[row_raddr];
			row_rd_vld_q <= row_valid_q[row_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (row_we)
			row_valid_q[row_waddr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD)
			q_mem[0] <= in_a;
		else if (op == OP_BSCAN && fb.found)
			q_mem[tail_q[VW-1:0]] <= fb.idx;
		if (op == OP_BPOP && head_q != tail_q)
			q_rd_q <= q_mem[head_q[VW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (op == OP_DSCAN && fd.found && emit_ok)
			s_mem[sp_q[VW-1:0]] <= '{v: cur_v_q, nxt: CW'(fd.idx) + CW'(1)};
		if (op == OP_DSCAN && !fd.found && sp_q != '0)
			s_rd_q <= s_mem[sp_q[VW-1:0] - VW'(1)];
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				act_q <= in_action;
				a_q <= in_a;
				b_q <= in_b;
				visited_q <= N'(1) << in_a;
				head_q <= '0;
				tail_q <= CW'(1);
				sp_q <= '0;
				cur_v_q <= in_a;
				cur_next_q <= '0;
			end
			OP_BPOP: begin
				if (head_q != tail_q)
					head_q <= head_q + CW'(1);
			end
			OP_BSCAN: begin
				if (fb.found) begin
					visited_q[fb.idx] <= 1'b1;
					tail_q <= tail_q + CW'(1);
				end
			end
			OP_DSCAN: begin
				if (fd.found) begin
					if (emit_ok) begin
						visited_q[fd.idx] <= 1'b1;
						sp_q <= sp_q + CW'(1);
						cur_v_q <= fd.idx;
						cur_next_q <= '0;
					end
				end else if (sp_q != '0)
					sp_q <= sp_q - CW'(1);
			end
			OP_DPOP: begin
				cur_v_q <= s_rd_q.v;
				cur_next_q <= s_rd_q.nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			pend_v_q <= (!oor && in_action == ACT_DFS) ? in_a : '0;
			pend_st_q <= oor;
		end else if (emit_now) begin
			pend_v_q <= emit_v;
			pend_st_q <= 1'b0;
		end else if ((op == OP_EDGE_A && !need) || op == OP_EDGE_B) begin
			pend_v_q <= '0;
			pend_st_q <= 1'b0;
		end
		if (push) begin
			out_vertex <= pend_v_q;
			out_status <= pend_st_q;
			out_last <= (op == OP_FLUSH);
			out_edges <= edges_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
			edges_q <= '0;
			vcount_q <= VCOUNT_RESET;
		end else begin
			if (cfg_we)
				vcount_q <= cfg_wdata;
			if (op == OP_EDGE_B)
				edges_q <= ins ? edges_q + EW'(1) : edges_q - EW'(1);
			if (op == OP_LOAD)
				pend_vld_q <= oor || (in_action == ACT_DFS);
			else if (emit_now || (op == OP_EDGE_A && !need) || op == OP_EDGE_B)
				pend_vld_q <= 1'b1;
			else if (op == OP_FLUSH && out_free)
				pend_vld_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/graph_matrix_bfs_dfs.sv =====
// Undirected graph on up to 64 vertices held as a symmetric adjacency bit matrix, one
// row per vertex in a memory, cleared at reset by per-row valid bits. An insert or remove
// request gives one result after the states EDGE_A, EDGE_B and FLUSH, skipping EDGE_B
// when the edge is already in the wanted state. A breadth- or depth-first walk gives one
// result per visited vertex with last set on the final one; each vertex costs a row read
// and a queue read breadth-first or a stack read depth-first, plus a scan step for each
// neighbour found, and the walk is held off while the output is stalled. A new request is
// taken only once the previous one has delivered its results to the output register.
module graph_matrix_bfs_dfs import gmbd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [CW-1:0] cfg_wdata,
	gmbd_in_if.sink       in_req,
	gmbd_out_if.source    out_rsp
);

	dp_op_t     op;
	dp_status_t st;

	gmbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_req.valid),
		.in_ready (in_req.ready),
		.st       (st),
		.op       (op)
	);

	gmbd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.st         (st),
		.in_action  (in_req.action),
		.in_a       (in_req.vertex_a),
		.in_b       (in_req.vertex_b),
		.out_valid  (out_rsp.valid),
		.out_ready  (out_rsp.ready),
		.out_vertex (out_rsp.visited_vertex),
		.out_last   (out_rsp.last),
		.out_status (out_rsp.status),
		.out_edges  (out_rsp.edge_count)
	);

endmodule
